>>> hdl/ppdf_pkg.sv
package ppdf_pkg;

   localparam int FACE_SLOTS_DEFAULT = 3;

   localparam int PRESSURE_W = 16;
   localparam int TIME_W     = 32;
   localparam int DEPTH_W    = 16;
   localparam int DEFAULT_W  = 16;
   localparam int MULT_W     = 8;
   localparam int WARMUP_W   = 8;
   localparam int COUNT_W    = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 8;
   // expected interval times a Q4.4 factor, fraction dropped
   localparam int TIMEOUT_W  = TIME_W + MULT_W - 4;

   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 120;
   localparam int RSP_USER_W  = 3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_DIP_DEPTH       = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DEFAULT_INTERVAL_MS = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TIMEOUT_MULTIPLIER  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_WARMUP_PULSES       = 8'd3;

   localparam logic [DEPTH_W-1:0]   CFG_RESET_MIN_DIP_DEPTH    = 16'd256;
   localparam logic [DEFAULT_W-1:0] CFG_RESET_DEFAULT_INTERVAL = 16'd500;
   localparam logic [MULT_W-1:0]    CFG_RESET_TIMEOUT_MULT     = 8'd32;
   localparam logic [WARMUP_W-1:0]  CFG_RESET_WARMUP_PULSES    = 8'd3;

   // face event codes
   localparam logic [1:0] EVENT_NONE    = 2'd0;
   localparam logic [1:0] EVENT_NATURAL = 2'd1;
   localparam logic [1:0] EVENT_FORCED  = 2'd2;

   typedef struct packed {
      logic [DEPTH_W-1:0]   min_dip_depth;
      logic [DEFAULT_W-1:0] default_interval_ms;
      logic [MULT_W-1:0]    timeout_multiplier;
      logic [WARMUP_W-1:0]  warmup_pulses;
   } cfg_type;

   typedef struct packed {
      logic                  fire;
      logic                  natural;
      logic [PRESSURE_W-1:0] value;
   } confirm_type;

   typedef struct packed {
      logic                  slot_recorded;
      logic [1:0]            face_slot;
      logic [PRESSURE_W-1:0] face_minimum;
      logic [TIME_W-1:0]     pulse_interval;
      logic [TIME_W-1:0]     interval_total;
      logic [COUNT_W-1:0]    interval_tally;
   } rec_type;

endpackage

>>> hdl/pulse_peak_dip_face_tracker.sv
// Pulse peak/dip tracker with per-face minimum slots.
//
// Input stream (req_): one pressure sample with its millisecond time stamp per
// transaction. Result stream (rsp_): exactly one result per sample, in order,
// carrying the confirmation event, the confirmed value, the face slot and its
// stored minimum, and the interval statistics as they stand after the sample.
// Configuration: csr_we writes csr_wdata to register csr_index;
// unknown indexes are dropped. Write only while no sample is in flight.
//
// An accepted sample waits in the input register, then its result is written
// to the result register on rsp_. Throughput is one sample per cycle while
// rsp_tready is high: a single input register feeds one pass of compare and
// state update to the result register, a 32x8 timeout multiply to timeout_ff.
//
// When the receiver stalls, the result register holds and the input register
// takes one more sample, then req_tready drops until rsp_tready returns.
// Reset clears all tracking state, slots and statistics and loads the register
// defaults; req_tready is low while reset is high.
module pulse_peak_dip_face_tracker #(
   parameter int FACE_SLOTS = ppdf_pkg::FACE_SLOTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pressure[15:0], now_ms[47:16]
   input  logic [ppdf_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // face_value[15:0], face_slot[17:16], face_minimum[33:18],
   // pulse_interval[65:34], interval_total[97:66], interval_tally[113:98], zero fill
   output logic [ppdf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // face_event[1:0], slot_recorded[2]
   output logic [ppdf_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  logic                                csr_we,
   input  logic [ppdf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ppdf_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ppdf_pkg::*;

   cfg_type               cfg_ff;
   logic                  in_valid_ff;
   logic [PRESSURE_W-1:0] pressure_ff;
   logic [TIME_W-1:0]     now_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   logic                  advance;
   logic                  req_take;
   logic [1:0]            face_event;
   confirm_type           confirm;
   rec_type               rec;
   logic [TIMEOUT_W-1:0]  timeout;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !reset && (!in_valid_ff || advance);
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_dip_depth       <= CFG_RESET_MIN_DIP_DEPTH;
         cfg_ff.default_interval_ms <= CFG_RESET_DEFAULT_INTERVAL;
         cfg_ff.timeout_multiplier  <= CFG_RESET_TIMEOUT_MULT;
         cfg_ff.warmup_pulses       <= CFG_RESET_WARMUP_PULSES;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MIN_DIP_DEPTH:       cfg_ff.min_dip_depth       <= csr_wdata;
            REG_DEFAULT_INTERVAL_MS: cfg_ff.default_interval_ms <= csr_wdata;
            REG_TIMEOUT_MULTIPLIER:  cfg_ff.timeout_multiplier  <= csr_wdata[MULT_W-1:0];
            REG_WARMUP_PULSES:       cfg_ff.warmup_pulses       <= csr_wdata[WARMUP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         pressure_ff <= req_tdata[PRESSURE_W-1:0];
         now_ff      <= req_tdata[PRESSURE_W +: TIME_W];
      end
   end

   ppdf_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .pressure   (pressure_ff),
      .now_ms     (now_ff),
      .cfg        (cfg_ff),
      .timeout    (timeout),
      .face_event (face_event),
      .confirm    (confirm)
   );

   ppdf_recorder #(
      .FACE_SLOTS (FACE_SLOTS)
   ) u_recorder (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .confirm (confirm),
      .now_ms  (now_ff),
      .cfg     (cfg_ff),
      .timeout (timeout),
      .rec     (rec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {6'b000000, rec.interval_tally, rec.interval_total,
                         rec.pulse_interval, rec.face_minimum, rec.face_slot,
                         confirm.value & {PRESSURE_W{confirm.fire}}};
         rsp_user_ff <= {rec.slot_recorded, face_event};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef NO_ASSERTIONS
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(pressure_ff) && $stable(now_ff))
      else $error("pending sample lost while stalled");

   a_record_needs_event: assert property (@(posedge clock) disable iff (reset)
      advance && rec.slot_recorded |-> confirm.fire && face_event != EVENT_NONE)
      else $error("slot recorded without a confirmation");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !advance)
      else $error("result overwritten while stalled");
`endif

endmodule

>>> hdl/ppdf_tracker.sv
module ppdf_tracker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [ppdf_pkg::PRESSURE_W-1:0]     pressure,
   input  logic [ppdf_pkg::TIME_W-1:0]         now_ms,
   input  ppdf_pkg::cfg_type                   cfg,
   input  logic [ppdf_pkg::TIMEOUT_W-1:0]      timeout,
   output logic [1:0]                          face_event,
   output ppdf_pkg::confirm_type               confirm
);
   import ppdf_pkg::*;

   logic                  rising_ff, rising_in;
   logic [PRESSURE_W-1:0] peak_ff, peak_in;
   logic [PRESSURE_W-1:0] trough_ff, trough_in;
   logic [TIME_W-1:0]     wstart_ff, wstart_in;
   logic                  wvalid_ff;

   logic [TIME_W-1:0]     wstart_eff;
   logic [TIME_W-1:0]     elapsed;
   logic                  expired;
   logic [PRESSURE_W-1:0] peak_new, trough_new;
   logic [PRESSURE_W-1:0] swing;
   logic                  amp;

   always_comb begin
      // first sample opens the window at its own time stamp
      wstart_eff = wvalid_ff ? wstart_ff : now_ms;
      elapsed    = now_ms - wstart_eff;
      expired    = TIMEOUT_W'(elapsed) > timeout;

      peak_new   = (pressure > peak_ff) ? pressure : peak_ff;
      trough_new = (pressure < trough_ff) ? pressure : trough_ff;
      swing      = rising_ff ? (peak_new - pressure) : (pressure - trough_new);
      amp        = swing > cfg.min_dip_depth;

      rising_in  = rising_ff;
      peak_in    = rising_ff ? peak_new : peak_ff;
      trough_in  = rising_ff ? trough_ff : trough_new;
      wstart_in  = wstart_eff;
      face_event = EVENT_NONE;
      confirm    = '{fire: 1'b0, natural: 1'b0, value: '0};

      priority if (rising_ff && amp) begin
         face_event    = EVENT_NATURAL;
         confirm.fire  = 1'b1;
         confirm.natural = 1'b1;
         confirm.value = peak_new;
         rising_in     = 1'b0;
         trough_in     = pressure;
         wstart_in     = now_ms;
      end else if (amp) begin
         rising_in = 1'b1;
         peak_in   = pressure;
      end else if (expired) begin
         face_event    = EVENT_FORCED;
         confirm.fire  = 1'b1;
         confirm.value = rising_ff ? peak_new : pressure;
         rising_in     = 1'b1;
         peak_in       = pressure;
         wstart_in     = now_ms;
      end else begin
         face_event = EVENT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rising_ff <= 1'b0;
         peak_ff   <= '0;
         trough_ff <= '0;
         wstart_ff <= '0;
         wvalid_ff <= 1'b0;
      end else if (step) begin
         rising_ff <= rising_in;
         peak_ff   <= peak_in;
         trough_ff <= trough_in;
         wstart_ff <= wstart_in;
         wvalid_ff <= 1'b1;
      end
   end

endmodule

>>> hdl/ppdf_recorder.sv
module ppdf_recorder #(
   parameter int FACE_SLOTS = ppdf_pkg::FACE_SLOTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  ppdf_pkg::confirm_type            confirm,
   input  logic [ppdf_pkg::TIME_W-1:0]      now_ms,
   input  ppdf_pkg::cfg_type                cfg,
   output logic [ppdf_pkg::TIMEOUT_W-1:0]   timeout,
   output ppdf_pkg::rec_type                rec
);
   import ppdf_pkg::*;

   localparam int SlotW = (FACE_SLOTS > 1) ? $clog2(FACE_SLOTS) : 1;
   localparam int ProdW = TIME_W + MULT_W;
   localparam logic [ProdW-1:0] ResetProd =
      ProdW'(CFG_RESET_DEFAULT_INTERVAL) * ProdW'(CFG_RESET_TIMEOUT_MULT);

   logic [TIME_W-1:0]     prev_time_ff;
   logic                  prev_valid_ff;
   logic                  prev_forced_ff;
   logic [TIME_W-1:0]     last_ff, last_in;
   logic [COUNT_W-1:0]    pulse_count_ff;
   logic [SlotW-1:0]      slot_ff, slot_in;
   logic [TIME_W-1:0]     sum_ff, sum_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [PRESSURE_W-1:0] minima_ff [FACE_SLOTS];
   logic [FACE_SLOTS-1:0] has_ff;
   logic [TIMEOUT_W-1:0]  timeout_ff;

   logic                  fire;
   logic                  take_iv;
   logic                  record;
   logic [TIME_W-1:0]     iv;
   logic [TIME_W:0]       sum_wide;
   logic [PRESSURE_W-1:0] cur_min, new_min;
   logic [SlotW+1:0]      slot_ext;
   logic [TIME_W-1:0]     expected_next;
   logic [ProdW-1:0]      prod;

   always_comb begin
      fire     = step && confirm.fire;
      iv       = now_ms - prev_time_ff;
      take_iv  = confirm.natural && !prev_forced_ff && prev_valid_ff;
      record   = pulse_count_ff >= COUNT_W'(cfg.warmup_pulses);
      cur_min  = minima_ff[slot_ff];
      new_min  = (!has_ff[slot_ff] || confirm.value < cur_min) ? confirm.value : cur_min;
      sum_wide = {1'b0, sum_ff} + {1'b0, iv};

      last_in  = (fire && take_iv) ? iv : last_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      if (fire && record && take_iv) begin
         sum_in = sum_wide[TIME_W] ? '1 : sum_wide[TIME_W-1:0];
         if (count_ff != '1) begin
            count_in = count_ff + 1'b1;
         end
      end
      slot_in = (slot_ff == SlotW'(FACE_SLOTS - 1)) ? '0 : slot_ff + 1'b1;

      // timeout for the next sample, from the interval this one leaves
      expected_next = (last_in != '0) ? last_in : TIME_W'(cfg.default_interval_ms);
      prod          = ProdW'(expected_next) * ProdW'(cfg.timeout_multiplier);

      slot_ext          = {2'b00, slot_ff};
      rec.slot_recorded = fire && record;
      rec.face_slot     = rec.slot_recorded ? slot_ext[1:0] : 2'b00;
      rec.face_minimum  = rec.slot_recorded ? new_min : '0;
      rec.pulse_interval = last_in;
      rec.interval_total = sum_in;
      rec.interval_tally = count_in;
   end

   assign timeout = timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff   <= '0;
         prev_valid_ff  <= 1'b0;
         prev_forced_ff <= 1'b0;
         last_ff        <= '0;
         pulse_count_ff <= '0;
         slot_ff        <= '0;
         sum_ff         <= '0;
         count_ff       <= '0;
         has_ff         <= '0;
         timeout_ff     <= ResetProd[ProdW-1:4];
      end else begin
         timeout_ff <= prod[ProdW-1:4];
         if (fire) begin
            prev_time_ff   <= now_ms;
            prev_valid_ff  <= 1'b1;
            prev_forced_ff <= !confirm.natural;
            last_ff        <= last_in;
            sum_ff         <= sum_in;
            count_ff       <= count_in;
            if (pulse_count_ff != '1) begin
               pulse_count_ff <= pulse_count_ff + 1'b1;
            end
            if (record) begin
               has_ff[slot_ff] <= 1'b1;
               slot_ff         <= slot_in;
            end
         end
      end
   end

   // minima need no reset: an entry is read only once its has bit is set
   always_ff @(posedge clock) begin
      if (fire && record) begin
         minima_ff[slot_ff] <= new_min;
      end
   end

`ifndef NO_ASSERTIONS
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SlotW'(FACE_SLOTS - 1))
      else $error("slot pointer out of range");

   a_min_bound: assert property (@(posedge clock) disable iff (reset)
      rec.slot_recorded |-> rec.face_minimum <= confirm.value)
      else $error("face minimum above confirmed value");

   a_tally_monotonic: assert property (@(posedge clock)
      !reset |=> reset || count_ff >= $past(count_ff))
      else $error("interval tally decreased");

   a_sum_follows_tally: assert property (@(posedge clock)
      !reset |=> reset || (sum_ff == $past(sum_ff)) ||
                 (count_ff != $past(count_ff)) || (count_ff == '1))
      else $error("interval sum moved without a counted interval");
`endif

endmodule
